FILE: rtl/approximate_median_background_assert.svh
// Assertion macros for the approximate median background block.
`ifndef APPROXIMATE_MEDIAN_BACKGROUND_ASSERT_SVH
`define APPROXIMATE_MEDIAN_BACKGROUND_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, quiet while in reset.
`define AMB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while in reset.
`define AMB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/amb_pkg.sv
// Types and constants shared by the approximate median background block.
`default_nettype none
package amb_pkg;

  localparam int PixW     = 8;
  localparam int CountW   = 17;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 9;

  localparam logic [CountW-1:0]  CountMax      = {CountW{1'b1}};
  localparam logic [CfgIdxW-1:0] CFG_ROW_COUNT = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_COL_COUNT = 8'd1;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } amb_state_e;

endpackage
`default_nettype wire

FILE: rtl/amb_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module amb_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/approximate_median_background.sv
// Top level of the approximate median background subtraction block.
`default_nettype none
// Takes grayscale pixels in raster order and nudges a per-position background value one
// step toward each pixel, counting exact matches over a frame. One pixel is accepted per
// clock when the output side keeps up; a result passes through the registered read of the
// frame store and then the modify-and-write stage into the output register, with
// forwarding between back-to-back pixels at the same position. After reset the store is
// swept to zero over all MAX_ROWS*MAX_COLS entries at one entry per cycle, and no pixel is
// taken during the sweep; register writes are taken at any time and apply from the next
// pixel accepted, mid-frame included.
module approximate_median_background
  import amb_pkg::*;
#(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [PixW-1:0]     pixel_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [PixW-1:0]          background_pixel_o,
  output logic                     pixel_matches_o,
  output logic                     frame_end_o,
  output logic [CountW-1:0]        equal_total_o
);

  `include "approximate_median_background_assert.svh"

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ColW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int RowLastRst = (256 > MAX_ROWS) ? MAX_ROWS - 1 : 255;
  localparam int ColLastRst = (256 > MAX_COLS) ? MAX_COLS - 1 : 255;
  localparam logic [AddrW-1:0] AddrLast = AddrW'(Depth - 1);
  localparam logic [AddrW-1:0] RowStep  = AddrW'(MAX_COLS);

  // Last valid index for a size register: zero counts as one, oversize clamps.
  function automatic int last_index(input logic [CfgDataW-1:0] size, input int limit);
    int sz;
    sz = int'(size);
    if (sz == 0) begin
      return 0;
    end else if (sz > limit) begin
      return limit - 1;
    end
    return sz - 1;
  endfunction

  // Configuration
  logic [RowW-1:0] row_last_q;
  logic [ColW-1:0] col_last_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_last_q <= RowW'(RowLastRst);
      col_last_q <= ColW'(ColLastRst);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROW_COUNT: row_last_q <= RowW'(last_index(cfg_data_i, MAX_ROWS));
        CFG_COL_COUNT: col_last_q <= ColW'(last_index(cfg_data_i, MAX_COLS));
        default: ;
      endcase
    end
  end

  // Clearing sweep after reset
  amb_state_e       state_q, state_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    clearing   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clearing   = 1'b1;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == AddrLast) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        clearing = 1'b0;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Handshake and stage control
  logic s1_v_q;
  logic out_valid_q;
  logic s1_adv, s1_fire, in_fire;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_v_q && s1_adv;
  assign in_ready_o = !clearing && (!s1_v_q || s1_adv);
  assign in_fire    = in_valid_i && in_ready_o;

  // Position tracking; base holds row * MAX_COLS
  logic [RowW-1:0]  row_q;
  logic [ColW-1:0]  col_q;
  logic [AddrW-1:0] base_q;
  logic [AddrW-1:0] rd_addr;
  logic             col_wrap, frame_wrap;

  assign rd_addr    = base_q + AddrW'(col_q);
  assign col_wrap   = (col_q >= col_last_q);
  assign frame_wrap = col_wrap && (row_q >= row_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      base_q <= '0;
    end else if (in_fire) begin
      if (!col_wrap) begin
        col_q <= col_q + 1'b1;
      end else begin
        col_q <= '0;
        if (frame_wrap) begin
          row_q  <= '0;
          base_q <= '0;
        end else begin
          row_q  <= row_q + 1'b1;
          base_q <= base_q + RowStep;
        end
      end
    end
  end

  // Read-modify-write stage
  logic [AddrW-1:0] s1_addr_q;
  logic [PixW-1:0]  s1_pix_q;
  logic             s1_end_q;
  logic             s1_fwd_q;
  logic [PixW-1:0]  s1_fwd_data_q;
  logic [PixW-1:0]  rd_data;
  logic [PixW-1:0]  old_bg, new_bg;
  logic             match;

  assign old_bg = s1_fwd_q ? s1_fwd_data_q : rd_data;
  assign match  = (s1_pix_q == old_bg);

  always_comb begin
    if (s1_pix_q > old_bg) begin
      new_bg = old_bg + 1'b1;
    end else if (s1_pix_q < old_bg) begin
      new_bg = old_bg - 1'b1;
    end else begin
      new_bg = old_bg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_fire) begin
      s1_v_q <= 1'b1;
    end else if (s1_fire) begin
      s1_v_q <= 1'b0;
    end
  end

  // Forward the value being written when the next pixel reads the same entry
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_addr_q     <= rd_addr;
      s1_pix_q      <= pixel_i;
      s1_end_q      <= frame_wrap;
      s1_fwd_q      <= s1_fire && (s1_addr_q == rd_addr);
      s1_fwd_data_q <= new_bg;
    end
  end

  // Match count
  logic [CountW-1:0] cnt_q;
  logic [CountW-1:0] cnt_next;

  assign cnt_next = (match && (cnt_q != CountMax)) ? cnt_q + 1'b1 : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (s1_fire) begin
      cnt_q <= s1_end_q ? '0 : cnt_next;
    end
  end

  // Output register
  logic [PixW-1:0]   out_bg_q;
  logic              out_match_q;
  logic              out_end_q;
  logic [CountW-1:0] out_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_bg_q    <= new_bg;
      out_match_q <= match;
      out_end_q   <= s1_end_q;
      out_total_q <= s1_end_q ? cnt_next : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign background_pixel_o = out_bg_q;
  assign pixel_matches_o    = out_match_q;
  assign frame_end_o        = out_end_q;
  assign equal_total_o      = out_total_q;

  // Frame store
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [PixW-1:0]  ram_wdata;

  assign ram_we    = clearing || s1_fire;
  assign ram_waddr = clearing ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clearing ? '0 : new_bg;

  amb_ram #(
    .Width(PixW),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_fire),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // Assertions
  `AMB_ASSERT_NOW(a_no_accept_clear, clearing, !in_ready_o, "pixel taken during clear")
  `AMB_ASSERT_NEXT(a_rd_hold, s1_v_q && !s1_adv, $stable(rd_data), "read data lost in stall")
  `AMB_ASSERT_NOW(a_total_zero, out_valid_o && !frame_end_o, equal_total_o == '0,
                  "count shown off frame end")
  `AMB_ASSERT_NOW(a_no_write_clash, clearing, !s1_v_q, "pixel in flight during clear")

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the approximate median background block.
module tb_top;
  import amb_pkg::*;

  localparam int MaxRows     = 256;
  localparam int MaxCols     = 256;
  localparam int PixelTarget = 1150;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_ROW_COUNT;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [PixW-1:0]     pixel_i     = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [PixW-1:0]     background_pixel_o;
  logic                pixel_matches_o;
  logic                frame_end_o;
  logic [CountW-1:0]   equal_total_o;

  int n_mismatch = 0;
  int n_writes   = 0;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int hold_req   = 0;
  int stall_left = 0;

  typedef struct {
    logic [PixW-1:0]   background;
    logic              is_match;
    logic              frame_end;
    logic [CountW-1:0] total;
  } bg_result_t;

  task automatic report_mismatch(input string what);
    n_mismatch++;
    if (n_mismatch <= 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  class background_tracker;
    bit [PixW-1:0]     store [MaxRows*MaxCols];
    int unsigned       row_pos;
    int unsigned       col_pos;
    bit [CountW-1:0]   match_cnt;
    bit [CfgDataW-1:0] row_reg;
    bit [CfgDataW-1:0] col_reg;
    bg_result_t        due_q[$];
    int unsigned       n_pixels;
    int unsigned       n_frames;
    int unsigned       n_matches;

    function new();
      foreach (store[i]) store[i] = '0;
      row_reg = 9'd256;
      col_reg = 9'd256;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CFG_ROW_COUNT) row_reg = val;
      else if (idx == CFG_COL_COUNT) col_reg = val;
    endfunction

    // Zero means one, anything past the store size means the full size.
    static function int unsigned clamp_size(bit [CfgDataW-1:0] r, int unsigned lim);
      if (r == 0) return 1;
      if (32'(r) > lim) return lim;
      return 32'(r);
    endfunction

    function bit [PixW-1:0] next_background();
      return store[row_pos * MaxCols + col_pos];
    endfunction

    function void take_pixel(logic [PixW-1:0] p);
      int unsigned rows;
      int unsigned cols;
      int unsigned addr;
      bg_result_t  res;
      rows = clamp_size(row_reg, MaxRows);
      cols = clamp_size(col_reg, MaxCols);
      addr = row_pos * MaxCols + col_pos;
      res.background = store[addr];
      res.is_match   = 1'b0;
      res.frame_end  = 1'b0;
      res.total      = '0;
      if (p > res.background) res.background++;
      else if (p < res.background) res.background--;
      else res.is_match = 1'b1;
      store[addr] = res.background;
      if (res.is_match) begin
        n_matches++;
        if (match_cnt != CountMax) match_cnt++;
      end
      // A position already past a shrunken size counts as the last one.
      if (col_pos + 1 >= cols) begin
        col_pos = 0;
        if (row_pos + 1 >= rows) begin
          row_pos       = 0;
          res.frame_end = 1'b1;
          res.total     = match_cnt;
          match_cnt     = '0;
          n_frames++;
        end else begin
          row_pos++;
        end
      end else begin
        col_pos++;
      end
      due_q.push_back(res);
      n_pixels++;
    endfunction

    task check_result(logic [PixW-1:0] b, logic m, logic fe, logic [CountW-1:0] tot);
      bg_result_t e;
      if (due_q.size() == 0) begin
        report_mismatch($sformatf("result with no pixel outstanding (background %0d)", b));
        return;
      end
      e = due_q.pop_front();
      if (b !== e.background)
        report_mismatch($sformatf("background_pixel %0d, want %0d", b, e.background));
      if (m !== e.is_match)
        report_mismatch($sformatf("pixel_matches %b, want %b", m, e.is_match));
      if (fe !== e.frame_end)
        report_mismatch($sformatf("frame_end %b, want %b", fe, e.frame_end));
      if (tot !== e.total)
        report_mismatch($sformatf("equal_total %0d, want %0d", tot, e.total));
    endtask

    function int pending();
      return due_q.size();
    endfunction
  endclass

  background_tracker tracker;

  approximate_median_background #(
    .MAX_ROWS(MaxRows),
    .MAX_COLS(MaxCols)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .pixel_i           (pixel_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .background_pixel_o(background_pixel_o),
    .pixel_matches_o   (pixel_matches_o),
    .frame_end_o       (frame_end_o),
    .equal_total_o     (equal_total_o)
  );

  always #1 clk_i = ~clk_i;

  // Output side: random stalls, plus a long hold when one is requested.
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      stall_left = hold_req;
      hold_req   = 0;
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (rst_ni && $urandom_range(99) < stall_pct) begin
      out_ready_i <= 1'b0;
      stall_left = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      out_ready_i <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_result(background_pixel_o, pixel_matches_o, frame_end_o, equal_total_o);
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(99) >= gap_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_pixel(input logic [PixW-1:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= p;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_pixel(p);
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, val);
    n_writes++;
    @(negedge clk_i);
  endtask

  task automatic set_frame(input bit wr_rows, input logic [CfgDataW-1:0] rows,
                           input bit wr_cols, input logic [CfgDataW-1:0] cols);
    if (wr_rows) write_register(CFG_ROW_COUNT, rows);
    if (wr_cols) write_register(CFG_COL_COUNT, cols);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Drop the request and wait until every result is back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Mostly steer the pixel onto or next to the stored background so that matches occur.
  function automatic logic [PixW-1:0] choose_pixel();
    logic [PixW-1:0] b;
    int unsigned     r;
    b = tracker.next_background();
    r = $urandom_range(99);
    if (r < 45) return b;
    if (r < 60) begin
      if (b == 8'd255 || (b != 8'd0 && $urandom_range(1) == 1)) return b - 8'd1;
      return b + 8'd1;
    end
    if (r < 66) return $urandom_range(1) ? 8'd255 : 8'd0;
    return PixW'($urandom_range(255));
  endfunction

  initial begin
    logic [PixW-1:0]     first_frame [6];
    logic [CfgDataW-1:0] rows;
    logic [CfgDataW-1:0] cols;
    bit                  wr_rows;
    bit                  wr_cols;
    int                  phase;
    int                  n_items;
    first_frame = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd0};
    tracker = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    gap_pct   = 20;
    stall_pct = 20;
    // Two by three frame with extreme pixels, then a frame that matches everywhere.
    set_frame(1'b1, 9'd2, 1'b1, 9'd3);
    foreach (first_frame[k]) send_pixel(first_frame[k]);
    repeat (6) send_pixel(tracker.next_background());
    // One-pixel frames hitting the same position back to back.
    settle();
    set_frame(1'b1, 9'd1, 1'b1, 9'd1);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd0);
    // Zero sizes act as one.
    settle();
    set_frame(1'b1, 9'd0, 1'b1, 9'd0);
    send_pixel(tracker.next_background());
    send_pixel(8'd7);
    // Oversized registers clamp to the full store, then shrink mid-frame.
    settle();
    set_frame(1'b1, 9'd511, 1'b1, 9'd257);
    repeat (5) send_pixel(PixW'($urandom_range(255)));
    settle();
    set_frame(1'b0, 9'd0, 1'b1, 9'd3);
    repeat (2) send_pixel(choose_pixel());
    settle();
    set_frame(1'b1, 9'd1, 1'b0, 9'd0);
    repeat (3) send_pixel(choose_pixel());

    phase = 0;
    while (tracker.n_pixels < PixelTarget) begin
      settle();
      if (phase % 4 == 0) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(10, 40);
        stall_pct = $urandom_range(10, 40);
      end
      case ($urandom_range(9))
        0: begin
          rows = 9'd256;
          cols = 9'd1;
        end
        1: begin
          rows = 9'd1;
          cols = 9'd256;
        end
        2: begin
          rows = 9'd0;
          cols = CfgDataW'($urandom_range(1, 8));
        end
        3: begin
          rows = CfgDataW'($urandom_range(257, 511));
          cols = CfgDataW'($urandom_range(0, 4));
        end
        default: begin
          rows = CfgDataW'($urandom_range(1, 6));
          cols = CfgDataW'($urandom_range(1, 12));
        end
      endcase
      wr_rows = (phase == 0) || ($urandom_range(3) != 0);
      wr_cols = (phase == 0) || ($urandom_range(3) != 0) || !wr_rows;
      set_frame(wr_rows, rows, wr_cols, cols);
      n_items = $urandom_range(20, 60);
      // Hold the output off long enough for the block to back up its input.
      if (phase == 2) begin
        gap_pct  = 0;
        n_items  = 80;
        hold_req = 300;
      end
      for (int k = 0; k < n_items; k++) begin
        if (k == n_items / 2 && (phase == 4 || $urandom_range(4) == 0)) settle();
        send_pixel(choose_pixel());
      end
      phase++;
    end
    settle();
    repeat (6) @(posedge clk_i);

    $display("Sent %0d pixels over %0d completed frames, %0d of them equal to the background.",
             tracker.n_pixels, tracker.n_frames, tracker.n_matches);
    $display("Made %0d register writes over %0d random phases; %0d mismatches seen.",
             n_writes, phase, n_mismatch);
    if (n_mismatch == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", tracker.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule
